// ===== design/rtcc_pkg.sv =====
package rtcc_pkg;

    localparam logic [7:0] BAD_BCD = 8'hFF;
    localparam logic [7:0] BCD_MAX = 8'h9F;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam logic [7:0] MONTHS = 8'd12;
    localparam logic [7:0] FEBRUARY = 8'd2;
    localparam logic [7:0] HOUR_MAX = 8'd24;
    localparam logic [7:0] MINUTE_MAX = 8'd60;
    localparam logic [7:0] SECOND_MAX = 8'd60;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [6:0] WRAP_24 = 7'd24;
    localparam logic [7:0] WRAP_60 = 8'd60;

    localparam logic [4:0] OFFSET_HOURS_MAX = 5'd23;
    localparam logic [5:0] OFFSET_MINUTES_MAX = 6'd59;
    localparam logic [5:0] OFFSET_SECONDS_MAX = 6'd59;

    localparam int unsigned FLAG_POWER = 0;
    localparam int unsigned FLAG_TWELVE = 1;
    localparam int unsigned FLAG_YEAR = 2;
    localparam int unsigned FLAG_MONTH = 3;
    localparam int unsigned FLAG_DAY = 4;
    localparam int unsigned FLAG_HOUR = 5;
    localparam int unsigned FLAG_MINUTE = 6;
    localparam int unsigned FLAG_SECOND = 7;

    localparam int unsigned STATUS_POWER_FAIL = 7;
    localparam int unsigned STATUS_24_HOUR = 6;

    typedef enum logic [1:0] {
        REG_OFFSET_DAYS,
        REG_OFFSET_HOURS,
        REG_OFFSET_MINUTES,
        REG_OFFSET_SECONDS
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] days;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } offset_t;

    typedef struct packed {
        logic [7:0]  flags;
        logic [15:0] day_count;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } check_t;

    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        if (b > BCD_MAX || b[3:0] > DIGIT_MAX) begin
            return BAD_BCD;
        end
        return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        case (m)
            4'd2: return 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default: return 5'd31;
        endcase
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd1: return 9'd0;
            4'd2: return 9'd31;
            4'd3: return 9'd59;
            4'd4: return 9'd90;
            4'd5: return 9'd120;
            4'd6: return 9'd151;
            4'd7: return 9'd181;
            4'd8: return 9'd212;
            4'd9: return 9'd243;
            4'd10: return 9'd273;
            4'd11: return 9'd304;
            4'd12: return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

endpackage

// ===== design/rtcc_cfg.sv =====
module rtcc_cfg
    import rtcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output offset_t     offset
);

    offset_t offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_OFFSET_DAYS: begin
                    offset_reg.days <= cfg_wdata;
                end
                REG_OFFSET_HOURS: begin
                    offset_reg.hours <= (cfg_wdata[4:0] > OFFSET_HOURS_MAX) ?
                        OFFSET_HOURS_MAX : cfg_wdata[4:0];
                end
                REG_OFFSET_MINUTES: begin
                    offset_reg.minutes <= (cfg_wdata[5:0] > OFFSET_MINUTES_MAX) ?
                        OFFSET_MINUTES_MAX : cfg_wdata[5:0];
                end
                REG_OFFSET_SECONDS: begin
                    offset_reg.seconds <= (cfg_wdata[5:0] > OFFSET_SECONDS_MAX) ?
                        OFFSET_SECONDS_MAX : cfg_wdata[5:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign offset = offset_reg;

endmodule

// ===== design/rtcc_check.sv =====
module rtcc_check
    import rtcc_pkg::*;
(
    input  logic [7:0] status_byte,
    input  logic [7:0] year_bcd,
    input  logic [7:0] month_bcd,
    input  logic [7:0] day_bcd,
    input  logic [7:0] hour_bcd,
    input  logic [7:0] minute_bcd,
    input  logic [7:0] second_bcd,
    output check_t     result
);

    logic [7:0]  year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic        year_ok;
    logic        month_ok;
    logic        leap;
    logic [4:0]  day_limit;
    logic [7:0]  flags;
    logic [6:0]  leap_days;
    logic [15:0] count;

    always_comb begin
        year = bcd_decode(year_bcd);
        month = bcd_decode(month_bcd);
        day = bcd_decode(day_bcd);
        hour = bcd_decode(hour_bcd);
        minute = bcd_decode(minute_bcd);
        second = bcd_decode(second_bcd);
        year_ok = (year != BAD_BCD);
        month_ok = (month != 8'd0) && (month <= MONTHS);
        // Within 2000..2099 a year is a leap year exactly when it divides by four.
        leap = (year[1:0] == 2'b00);

        day_limit = month_len(month[3:0]) +
                    {4'b0, (month == FEBRUARY) && year_ok && leap};

        flags = '0;
        flags[FLAG_POWER] = status_byte[STATUS_POWER_FAIL];
        flags[FLAG_TWELVE] = !status_byte[STATUS_24_HOUR];
        flags[FLAG_YEAR] = !year_ok;
        flags[FLAG_MONTH] = !month_ok;
        flags[FLAG_DAY] = (day == BAD_BCD) || (month_ok && (day > {3'b0, day_limit}));
        flags[FLAG_HOUR] = (hour > HOUR_MAX);
        flags[FLAG_MINUTE] = (minute > MINUTE_MAX);
        flags[FLAG_SECOND] = (second > SECOND_MAX);

        leap_days = 7'(({1'b0, year} + 9'd3) >> 2);
        count = 16'({8'b0, year} * DAYS_PER_YEAR) + {9'b0, leap_days} +
                {7'b0, month_start(month[3:0])} + {8'b0, day} +
                {15'b0, (month > FEBRUARY) && leap};

        result.flags = flags;
        result.day_count = (flags[FLAG_YEAR] || flags[FLAG_MONTH] || flags[FLAG_DAY]) ?
                           16'd0 : count;
        result.hour = hour;
        result.minute = minute;
        result.second = second;
    end

endmodule

// ===== design/rtcc_local.sv =====
module rtcc_local
    import rtcc_pkg::*;
(
    input  check_t             check,
    input  offset_t            offset,
    output logic signed [15:0] local_days,
    output logic [4:0]         local_hours,
    output logic [5:0]         local_minutes,
    output logic [5:0]         local_seconds
);

    logic [7:0]  sec_diff;
    logic [7:0]  min_diff;
    logic [6:0]  hour_diff;
    logic        sec_borrow;
    logic        min_borrow;
    logic        hour_borrow;
    logic [7:0]  sec_norm;
    logic [7:0]  min_norm;
    logic [6:0]  hour_norm;
    logic [15:0] days_diff;
    logic        clean;

    always_comb begin
        clean = (check.flags == 8'd0);

        sec_diff = {1'b0, check.second[6:0]} - {2'b0, offset.seconds};
        sec_borrow = sec_diff[7];
        sec_norm = sec_borrow ? sec_diff + WRAP_60 : sec_diff;

        min_diff = {1'b0, check.minute[6:0]} - {2'b0, offset.minutes} -
                   {7'b0, sec_borrow};
        min_borrow = min_diff[7];
        min_norm = min_borrow ? min_diff + WRAP_60 : min_diff;

        hour_diff = {2'b0, check.hour[4:0]} - {2'b0, offset.hours} -
                    {6'b0, min_borrow};
        hour_borrow = hour_diff[6];
        hour_norm = hour_borrow ? hour_diff + WRAP_24 : hour_diff;

        days_diff = check.day_count - offset.days - {15'b0, hour_borrow};

        local_seconds = clean ? sec_norm[5:0] : 6'd0;
        local_minutes = clean ? min_norm[5:0] : 6'd0;
        local_hours = clean ? hour_norm[4:0] : 5'd0;
        local_days = clean ? signed'(days_diff) : 16'sd0;
    end

endmodule

// ===== design/rtc_bcd_date_check_and_local_time.sv =====
// An input transfer is held in the input register and its result in the result register,
// with the checks and the local time computed by combinational logic between them.
// Throughput is one reading per cycle while the result side keeps taking transfers.
// Synchronous active-low reset empties both registers and clears all offsets to zero.
module rtc_bcd_date_check_and_local_time
    import rtcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_status_byte,
    input  logic [7:0]         s_year_bcd,
    input  logic [7:0]         s_month_bcd,
    input  logic [7:0]         s_day_bcd,
    input  logic [7:0]         s_hour_bcd,
    input  logic [7:0]         s_minute_bcd,
    input  logic [7:0]         s_second_bcd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_error_flags,
    output logic [15:0]        m_day_count,
    output logic signed [15:0] m_local_days,
    output logic [4:0]         m_local_hours,
    output logic [5:0]         m_local_minutes,
    output logic [5:0]         m_local_seconds
);

    offset_t            offset;
    check_t             check;
    logic signed [15:0] local_days;
    logic [4:0]         local_hours;
    logic [5:0]         local_minutes;
    logic [5:0]         local_seconds;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         status_reg;
    logic [7:0]         year_reg;
    logic [7:0]         month_reg;
    logic [7:0]         day_reg;
    logic [7:0]         hour_reg;
    logic [7:0]         minute_reg;
    logic [7:0]         second_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_ready;
    logic [7:0]         flags_reg;
    logic [15:0]        day_count_reg;
    logic signed [15:0] local_days_reg;
    logic [4:0]         local_hours_reg;
    logic [5:0]         local_minutes_reg;
    logic [5:0]         local_seconds_reg;

    rtcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .offset    (offset)
    );

    rtcc_check u_check (
        .status_byte (status_reg),
        .year_bcd    (year_reg),
        .month_bcd   (month_reg),
        .day_bcd     (day_reg),
        .hour_bcd    (hour_reg),
        .minute_bcd  (minute_reg),
        .second_bcd  (second_reg),
        .result      (check)
    );

    rtcc_local u_local (
        .check         (check),
        .offset        (offset),
        .local_days    (local_days),
        .local_hours   (local_hours),
        .local_minutes (local_minutes),
        .local_seconds (local_seconds)
    );

    always_comb begin
        out_ready = !out_valid_reg || m_ready;
        s_ready = !in_valid_reg || out_ready;
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            status_reg <= s_status_byte;
            year_reg <= s_year_bcd;
            month_reg <= s_month_bcd;
            day_reg <= s_day_bcd;
            hour_reg <= s_hour_bcd;
            minute_reg <= s_minute_bcd;
            second_reg <= s_second_bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && out_ready) begin
            flags_reg <= check.flags;
            day_count_reg <= check.day_count;
            local_days_reg <= local_days;
            local_hours_reg <= local_hours;
            local_minutes_reg <= local_minutes;
            local_seconds_reg <= local_seconds;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_error_flags = flags_reg;
    assign m_day_count = day_count_reg;
    assign m_local_days = local_days_reg;
    assign m_local_hours = local_hours_reg;
    assign m_local_minutes = local_minutes_reg;
    assign m_local_seconds = local_seconds_reg;

endmodule

// ===== tb/tb.sv =====
module tb
    import rtcc_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 100;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } clock_reading_t;

    typedef struct packed {
        logic [7:0]  flags;
        logic [15:0] day_count;
        logic [15:0] days;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } clock_result_t;

    typedef enum {
        RX_STEADY,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    class date_scoreboard;
        logic [15:0] off_days;
        logic [4:0] off_hours;
        logic [5:0] off_minutes;
        logic [5:0] off_seconds;
        clock_result_t expected_q[$];
        int unsigned mismatches;

        function new();
            off_days = '0;
            off_hours = '0;
            off_minutes = '0;
            off_seconds = '0;
            mismatches = 0;
        endfunction

        function void set_offset(cfg_reg_t idx, logic [15:0] v);
            case (idx)
                REG_OFFSET_DAYS: off_days = v;
                REG_OFFSET_HOURS: off_hours = (v[4:0] > OFFSET_HOURS_MAX) ?
                                              OFFSET_HOURS_MAX : v[4:0];
                REG_OFFSET_MINUTES: off_minutes = (v[5:0] > OFFSET_MINUTES_MAX) ?
                                                  OFFSET_MINUTES_MAX : v[5:0];
                REG_OFFSET_SECONDS: off_seconds = (v[5:0] > OFFSET_SECONDS_MAX) ?
                                                  OFFSET_SECONDS_MAX : v[5:0];
                default: ;
            endcase
        endfunction

        function int unsigned bcd_value(logic [7:0] b);
            if (b > BCD_MAX || b[3:0] > 4'd9) begin
                return BAD_BCD;
            end
            return 10 * b[7:4] + b[3:0];
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(int unsigned m);
            case (m)
                2: return 28;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        function clock_result_t predict(clock_reading_t r);
            int unsigned yr, mo, dy, hr, mi, se, lim, total;
            int lsec, lmin, lhr;
            logic [15:0] ldays;
            clock_result_t e;
            yr = bcd_value(r.year);
            mo = bcd_value(r.month);
            dy = bcd_value(r.day);
            hr = bcd_value(r.hour);
            mi = bcd_value(r.minute);
            se = bcd_value(r.second);
            e = '0;
            if (r.status[STATUS_POWER_FAIL]) e.flags[FLAG_POWER] = 1'b1;
            if (!r.status[STATUS_24_HOUR]) e.flags[FLAG_TWELVE] = 1'b1;
            if (yr == BAD_BCD) e.flags[FLAG_YEAR] = 1'b1;
            if (mo == 0 || mo > MONTHS) e.flags[FLAG_MONTH] = 1'b1;
            if (dy == BAD_BCD) begin
                e.flags[FLAG_DAY] = 1'b1;
            end else if (mo >= 1 && mo <= MONTHS) begin
                lim = days_in_month(mo);
                if (mo == FEBRUARY && yr != BAD_BCD && is_leap(yr)) lim++;
                if (dy > lim) e.flags[FLAG_DAY] = 1'b1;
            end
            if (hr > HOUR_MAX) e.flags[FLAG_HOUR] = 1'b1;
            if (mi > MINUTE_MAX) e.flags[FLAG_MINUTE] = 1'b1;
            if (se > SECOND_MAX) e.flags[FLAG_SECOND] = 1'b1;

            if (!e.flags[FLAG_YEAR] && !e.flags[FLAG_MONTH] && !e.flags[FLAG_DAY]) begin
                total = DAYS_PER_YEAR * yr + (yr + 3) / 4 + dy;
                for (int m = 1; m < mo; m++) total += days_in_month(m);
                if (mo > FEBRUARY && is_leap(yr)) total++;
                e.day_count = total[15:0];
            end

            if (e.flags == '0) begin
                lsec = int'(se) - int'(off_seconds);
                lmin = int'(mi) - int'(off_minutes);
                lhr = int'(hr) - int'(off_hours);
                ldays = e.day_count - off_days;
                if (lsec < 0) begin
                    lsec += 60;
                    lmin--;
                end
                if (lmin < 0) begin
                    lmin += 60;
                    lhr--;
                end
                if (lhr < 0) begin
                    lhr += 24;
                    ldays = ldays - 16'd1;
                end
                e.days = ldays;
                e.hours = lhr[4:0];
                e.minutes = lmin[5:0];
                e.seconds = lsec[5:0];
            end
            return e;
        endfunction

        function void note_reading(clock_reading_t r);
            expected_q.push_back(predict(r));
        endfunction

        function void check_result(clock_result_t got);
            clock_result_t exp;
            bit ok;
            if (expected_q.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("Result with no pending reading: flags=%h count=%0d", got.flags,
                             got.day_count);
                end
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            ok = (got.flags === exp.flags) && (got.day_count === exp.day_count) &&
                 (got.days === exp.days) && (got.hours === exp.hours) &&
                 (got.minutes === exp.minutes) && (got.seconds === exp.seconds);
            if (!ok) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("Mismatch: expected flags=%h count=%0d local=%0d %0d:%0d:%0d",
                             exp.flags, exp.day_count, $signed(exp.days), exp.hours,
                             exp.minutes, exp.seconds);
                    $display("          actual   flags=%h count=%0d local=%0d %0d:%0d:%0d",
                             got.flags, got.day_count, $signed(got.days), got.hours,
                             got.minutes, got.seconds);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_status_byte = '0;
    logic [7:0] s_year_bcd = '0;
    logic [7:0] s_month_bcd = '0;
    logic [7:0] s_day_bcd = '0;
    logic [7:0] s_hour_bcd = '0;
    logic [7:0] s_minute_bcd = '0;
    logic [7:0] s_second_bcd = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_error_flags;
    logic [15:0] m_day_count;
    logic signed [15:0] m_local_days;
    logic [4:0] m_local_hours;
    logic [5:0] m_local_minutes;
    logic [5:0] m_local_seconds;

    bit hold_request = 1'b0;
    int cycle_count = 0;
    date_scoreboard sb = new();

    rtc_bcd_date_check_and_local_time dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_status_byte(s_status_byte),
        .s_year_bcd(s_year_bcd),
        .s_month_bcd(s_month_bcd),
        .s_day_bcd(s_day_bcd),
        .s_hour_bcd(s_hour_bcd),
        .s_minute_bcd(s_minute_bcd),
        .s_second_bcd(s_second_bcd),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_error_flags(m_error_flags),
        .m_day_count(m_day_count),
        .m_local_days(m_local_days),
        .m_local_hours(m_local_hours),
        .m_local_minutes(m_local_minutes),
        .m_local_seconds(m_local_seconds)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_reading({s_status_byte, s_year_bcd, s_month_bcd, s_day_bcd,
                                 s_hour_bcd, s_minute_bcd, s_second_bcd});
            end
            if (m_valid && m_ready) begin
                sb.check_result({m_error_flags, m_day_count, m_local_days, m_local_hours,
                                 m_local_minutes, m_local_seconds});
            end
        end
    end

    // The receiver picks a new random behavior for each span and honors a request
    // for one long hold-off.
    initial begin
        rx_mode_t mode;
        int span, on_len, off_len;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 2));
            span = $urandom_range(20, 120);
            on_len = $urandom_range(1, 6);
            off_len = $urandom_range(1, 6);
            for (int c = 0; c < span; c++) begin
                @(posedge aclk);
                if (hold_request) begin
                    hold_request = 1'b0;
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                case (mode)
                    RX_STEADY: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ((c % (on_len + off_len)) < on_len);
                endcase
            end
        end
    end

    function automatic logic [7:0] to_bcd(int unsigned v);
        logic [7:0] b;
        b[7:4] = 4'(v / 10);
        b[3:0] = 4'(v % 10);
        return b;
    endfunction

    function automatic clock_reading_t good_reading();
        int unsigned yr, mo, lim;
        clock_reading_t r;
        yr = $urandom_range(0, 99);
        mo = $urandom_range(1, 12);
        lim = sb.days_in_month(mo);
        if (mo == FEBRUARY && sb.is_leap(yr)) lim++;
        r.status = {1'b0, 1'b1, 6'($urandom)};
        r.year = to_bcd(yr);
        r.month = to_bcd(mo);
        r.day = to_bcd($urandom_range(0, lim));
        r.hour = to_bcd($urandom_range(0, 24));
        r.minute = to_bcd($urandom_range(0, 60));
        r.second = to_bcd($urandom_range(0, 60));
        return r;
    endfunction

    function automatic clock_reading_t noisy_reading();
        int unsigned yr;
        clock_reading_t r;
        r = good_reading();
        case ($urandom_range(0, 8))
            0: r.status = 8'($urandom);
            1: r.year = 8'($urandom);
            2: r.month = 8'($urandom);
            3: r.day = 8'($urandom);
            4: r.hour = 8'($urandom);
            5: r.minute = 8'($urandom);
            6: r.second = 8'($urandom);
            7: r = {32'($urandom), 24'($urandom)};
            default: begin
                yr = $urandom_range(0, 99);
                r.year = to_bcd(yr);
                r.month = to_bcd(FEBRUARY);
                r.day = sb.is_leap(yr) ? 8'h30 : 8'h29;
            end
        endcase
        return r;
    endfunction

    task automatic send(clock_reading_t r);
        s_valid <= 1'b1;
        s_status_byte <= r.status;
        s_year_bcd <= r.year;
        s_month_bcd <= r.month;
        s_day_bcd <= r.day;
        s_hour_bcd <= r.hour;
        s_minute_bcd <= r.minute;
        s_second_bcd <= r.second;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(int count, bit no_gaps);
        int burst_left, gap;
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < count; i++) begin
            send(($urandom_range(0, 9) < 7) ? good_reading() : noisy_reading());
            burst_left--;
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0 && !no_gaps) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.set_offset(idx, v);
        @(posedge aclk);
    endtask

    task automatic program_offsets(logic [15:0] d, logic [15:0] h, logic [15:0] mi,
                                   logic [15:0] se);
        write_reg(REG_OFFSET_DAYS, d);
        write_reg(REG_OFFSET_HOURS, h);
        write_reg(REG_OFFSET_MINUTES, mi);
        write_reg(REG_OFFSET_SECONDS, se);
        cfg_we <= 1'b0;
    endtask

    task automatic send_directed();
        send({8'h40, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
        send({8'h40, 8'h99, 8'h12, 8'h31, 8'h24, 8'h60, 8'h60});
        send({8'h40, 8'h00, 8'h02, 8'h29, 8'h12, 8'h30, 8'h30});
        send({8'h40, 8'h01, 8'h02, 8'h29, 8'h08, 8'h15, 8'h45});
        send({8'h40, 8'h04, 8'h02, 8'h30, 8'h08, 8'h15, 8'h45});
        send({8'h40, 8'h00, 8'h13, 8'h99, 8'h01, 8'h02, 8'h03});
        send({8'h40, 8'h00, 8'h00, 8'h3A, 8'h01, 8'h02, 8'h03});
        send({8'h40, 8'hA0, 8'h05, 8'h15, 8'h10, 8'h20, 8'h30});
        send({8'h40, 8'h1A, 8'h05, 8'h15, 8'h10, 8'h20, 8'h30});
        send({8'h00, 8'h21, 8'h06, 8'h30, 8'h23, 8'h59, 8'h59});
        send({8'h80, 8'h21, 8'h06, 8'h31, 8'h23, 8'h59, 8'h59});
        send({8'hC0, 8'h21, 8'h07, 8'h00, 8'h25, 8'h61, 8'h61});
        send({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send({8'h40, 8'h23, 8'h04, 8'h31, 8'h23, 8'h59, 8'h59});
        send({8'h7F, 8'h96, 8'h11, 8'h30, 8'h00, 8'h00, 8'h00});
        send({8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_directed();
        send_random(60, 1'b0);
        drain();
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: program_offsets(16'h7FFF, 16'd23, 16'd59, 16'd59);
                1: program_offsets(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: program_offsets(16'hFFFF, 16'd24, 16'd60, 16'd60);
                3: program_offsets(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                4: program_offsets(16'd1, 16'd0, 16'd0, 16'd1);
                default: program_offsets(16'($urandom), 16'($urandom_range(0, 31)),
                                         16'($urandom_range(0, 63)),
                                         16'($urandom_range(0, 63)));
            endcase
            send_random(65, p == 3);
            if (p == 0) begin
                // Keep offering transfers while the receiver is held off.
                hold_request = 1'b1;
                send_random(40, 1'b1);
            end
            drain();
        end
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
